FILE: hw/rtl/dpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpp_pkg: shared types and constants of the dominance pruning picker
// Table sizes, input modes and the cell control struct.
// ----------------------------------------------------------------------------
package dpp_pkg;

  localparam int unsigned MaxEntries = 32;
  localparam int unsigned NumColumns = 16;
  localparam int unsigned BoundBits  = 8;
  localparam int unsigned RhsBits    = 16;
  localparam int unsigned SlotBits   = 5;
  localparam int unsigned CountBits  = $clog2(MaxEntries + 1);
  localparam int unsigned ColBits    = 4;

  typedef logic [BoundBits-1:0] bound_t;
  typedef bound_t [NumColumns-1:0] lhs_t;
  typedef logic [RhsBits-1:0] rhs_t;

  typedef enum logic [1:0] {
    ModeClear = 2'd0,
    ModeElem  = 2'd1,
    ModeClose = 2'd2,
    ModeDrain = 2'd3
  } mode_e;

  // Command from the controller to every cell.
  typedef struct packed {
    logic shift;   // rotate the chain by one cell
    logic load;    // write the candidate into cell count (the new tail)
    logic prune;   // apply candidate to the head cell before it moves
    lhs_t lhs;
    rhs_t cand;
  } cell_ctl_t;

  function automatic logic gen_le(input lhs_t a, input lhs_t b);
    logic ok;
    ok = 1'b1;
    for (int c = 0; c < NumColumns; c++) begin
      if (a[c] > b[c]) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/dpp_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpp_cell: one table entry of the rotating chain
// Holds bounds and bitset; passes them to the next cell on shift.
// ----------------------------------------------------------------------------
module dpp_cell (
  input  wire logic              clk_i,
  input  wire dpp_pkg::cell_ctl_t ctl_i,
  input  wire logic              is_tail_i,
  input  wire dpp_pkg::lhs_t     lhs_i,
  input  wire dpp_pkg::rhs_t     rhs_i,
  output dpp_pkg::lhs_t          lhs_o,
  output dpp_pkg::rhs_t          rhs_o
);

  dpp_pkg::lhs_t lhs_q;
  dpp_pkg::rhs_t rhs_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load && is_tail_i) begin
      lhs_q <= ctl_i.lhs;
      rhs_q <= ctl_i.cand;
    end else if (ctl_i.shift) begin
      lhs_q <= lhs_i;
      rhs_q <= rhs_i;
    end
  end

  assign lhs_o = lhs_q;
  assign rhs_o = rhs_q;

endmodule
`default_nettype wire

FILE: hw/rtl/dominance_pruning_picker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dominance_pruning_picker: batch rule table with generalization pruning
// Entries sit in a ring of cells; close and drain rotate it one place per cycle.
// ----------------------------------------------------------------------------
// channel | dir | handshake            | payload
// in      | in  | in_valid_i/in_ready_o| mode, column, bound, rhs_bits
// out     | out | out_valid_o/out_ready_i | slot, result_bits, entry_valid,
//         |     |                      | added, overflow, last
// Close rotates the ring once through all stored entries, one entry compared
// per cycle. Drain rotates the ring likewise, one result per cycle, stalled by
// out_ready_i.
// Reset empties the table; entry contents stay undefined.
// A result sits in an output register; the next request waits until it leaves.
// ----------------------------------------------------------------------------
module dominance_pruning_picker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [3:0]  column_i,
  input  wire logic [7:0]  bound_i,
  input  wire logic [15:0] rhs_bits_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [4:0]       slot_o,
  output logic [15:0]      result_bits_o,
  output logic             entry_valid_o,
  output logic             added_o,
  output logic             overflow_o,
  output logic             last_o
);

  localparam int unsigned N = dpp_pkg::MaxEntries;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StClose = 3'b010,
    StDrain = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [dpp_pkg::CountBits-1:0] count_q, count_d, step_q, step_d;
  dpp_pkg::lhs_t pend_q, pend_d;
  dpp_pkg::rhs_t cand_q, cand_d;
  logic stop_q, stop_d;

  logic ov_q, ov_d;
  logic [4:0] o_slot_q, o_slot_d;
  dpp_pkg::rhs_t o_bits_q, o_bits_d;
  logic o_ev_q, o_ev_d, o_add_q, o_add_d, o_ovf_q, o_ovf_d, o_last_q, o_last_d;

  dpp_pkg::cell_ctl_t ctl;
  dpp_pkg::lhs_t lhs_c [N];
  dpp_pkg::rhs_t rhs_c [N];
  dpp_pkg::lhs_t head_lhs;
  dpp_pkg::rhs_t head_rhs, head_new;
  logic cand_gen, head_gen;

  // Head is cell 0; shifting moves cell i+1 into i and the head into the tail
  // (cell count-1). Cells above the count hold nothing of interest.
  assign head_lhs = lhs_c[0];
  assign head_rhs = rhs_c[0];
  assign cand_gen = dpp_pkg::gen_le(pend_q, head_lhs);
  assign head_gen = dpp_pkg::gen_le(head_lhs, pend_q);
  assign head_new = (ctl.prune && cand_gen) ? (head_rhs & ~cand_q) : head_rhs;

  for (genvar g = 0; g < N; g++) begin : g_cell
    localparam logic [dpp_pkg::CountBits-1:0] Idx = dpp_pkg::CountBits'(g);
    dpp_pkg::lhs_t nl;
    dpp_pkg::rhs_t nr;
    if (g == N - 1) begin : g_last
      assign nl = head_lhs;
      assign nr = head_new;
    end else begin : g_mid
      logic tail;
      assign tail = (count_q - 1'b1) == Idx;
      assign nl = tail ? head_lhs : lhs_c[g+1];
      assign nr = tail ? head_new : rhs_c[g+1];
    end
    dpp_cell u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .is_tail_i(Idx == count_q),
      .lhs_i    (nl),
      .rhs_i    (nr),
      .lhs_o    (lhs_c[g]),
      .rhs_o    (rhs_c[g])
    );
  end

  assign in_ready_o = (state_q == StIdle) && !ov_q;

  always_comb begin
    state_d = state_q; count_d = count_q; step_d = step_q; pend_d = pend_q;
    cand_d = cand_q; stop_d = stop_q; ov_d = ov_q;
    o_slot_d = o_slot_q; o_bits_d = o_bits_q; o_ev_d = o_ev_q;
    o_add_d = o_add_q; o_ovf_d = o_ovf_q; o_last_d = o_last_q;
    ctl = '0;
    ctl.lhs = pend_q;
    ctl.cand = cand_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          case (dpp_pkg::mode_e'(mode_i))
            dpp_pkg::ModeClear: begin
              count_d = '0;
              pend_d = '0;
            end
            dpp_pkg::ModeElem: begin
              pend_d[column_i] = bound_i;
            end
            dpp_pkg::ModeClose: begin
              if (rhs_bits_i == '0 || count_q >= N[dpp_pkg::CountBits-1:0]) begin
                ov_d = 1'b1; o_slot_d = '0; o_bits_d = rhs_bits_i; o_ev_d = 1'b0;
                o_add_d = 1'b0; o_ovf_d = 1'b1; o_last_d = 1'b1;
                pend_d = '0;
              end else begin
                cand_d = rhs_bits_i; step_d = '0; stop_d = 1'b0;
                state_d = StClose;
              end
            end
            default: begin
              if (count_q == '0) begin
                ov_d = 1'b1; o_slot_d = '0; o_bits_d = '0; o_ev_d = 1'b0;
                o_add_d = 1'b0; o_ovf_d = 1'b0; o_last_d = 1'b1;
              end else begin
                step_d = '0;
                state_d = StDrain;
              end
            end
          endcase
        end
      end
      StClose: begin
        if (step_q < count_q) begin
          ctl.shift = 1'b1;
          ctl.prune = !stop_q;
          if (!stop_q && !cand_gen && head_gen) begin
            cand_d = cand_q & ~head_rhs;
            if ((cand_q & ~head_rhs) == '0) stop_d = 1'b1;
          end
          step_d = step_q + 1'b1;
        end else if (!ov_q) begin
          ov_d = 1'b1; o_ovf_d = 1'b0; o_last_d = 1'b1;
          if (cand_q == '0) begin
            o_slot_d = '0; o_bits_d = '0; o_ev_d = 1'b0; o_add_d = 1'b0;
          end else begin
            ctl.load = 1'b1;
            o_slot_d = count_q[4:0]; o_bits_d = cand_q; o_ev_d = 1'b1;
            o_add_d = 1'b1;
            count_d = count_q + 1'b1;
          end
          pend_d = '0;
          state_d = StIdle;
        end
      end
      StDrain: begin
        if (!ov_q || out_ready_i) begin
          ctl.shift = 1'b1;
          ov_d = 1'b1; o_slot_d = step_q[4:0]; o_bits_d = head_rhs; o_ev_d = 1'b1;
          o_add_d = 1'b0; o_ovf_d = 1'b0;
          o_last_d = (step_q + 1'b1) == count_q;
          step_d = step_q + 1'b1;
          if ((step_q + 1'b1) == count_q) begin
            count_d = '0;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      step_q <= '0;
      pend_q <= '0;
      stop_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q <= step_d;
      pend_q <= pend_d;
      stop_q <= stop_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    o_slot_q <= o_slot_d;
    o_bits_q <= o_bits_d;
    o_ev_q <= o_ev_d;
    o_add_q <= o_add_d;
    o_ovf_q <= o_ovf_d;
    o_last_q <= o_last_d;
  end

  assign out_valid_o = ov_q;
  assign slot_o = o_slot_q;
  assign result_bits_o = o_bits_q;
  assign entry_valid_o = o_ev_q;
  assign added_o = o_add_q;
  assign overflow_o = o_ovf_q;
  assign last_o = o_last_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= N[dpp_pkg::CountBits-1:0]) else $error("entry count overflow");
  a_idle_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDrain |-> count_q != '0) else $error("drain with empty table");
  a_add_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && added_o |-> entry_valid_o && !overflow_o && last_o)
    else $error("bad append flags");

endmodule
`default_nettype wire
